[rtl/jtt_pkg.sv]
// ----------------------------------------------------------------------------
// jtt_pkg
// Shared widths, register and command codes, and control structs of the
// joint trapezoid trajectory core.
// ----------------------------------------------------------------------------
package jtt_pkg;

  localparam int unsigned NUM_AXES_DEF      = 7;
  localparam int unsigned FRACTION_BITS_DEF = 16;

  localparam int unsigned AXIS_W     = 3;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned VMAX_W     = 32;
  localparam int unsigned ACCEL_W    = 24;
  localparam int unsigned VEL_W      = 33;
  localparam int unsigned MUL_LO_W   = 24;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [VMAX_W-1:0]  VMAX_RESET  = 32'd10937041;
  localparam logic [ACCEL_W-1:0] ACCEL_RESET = 24'd87496;

  localparam logic [CFG_IDX_W-1:0] REG_VMAX  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL = 1'b1;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  typedef struct packed {
    logic vld;
    logic last;
    logic pv_ok;
    logic goal_ok;
  } jtt_issue_t;

  typedef struct packed {
    logic strobe;
    logic last;
  } jtt_res_t;

endpackage

[rtl/joint_trapezoid_trajectory_core.sv]
// ----------------------------------------------------------------------------
// joint_trapezoid_trajectory_core
// Multi-axis trapezoidal velocity profile generator with per-axis state
// held in RAM.
//
//   channel   ports                                          handshake
//   command   start_i busy_o command_i axis_i                start & !busy
//             target_counts_i
//   result    result_strobe_o axis_out_o position_counts_o   strobe, 1 cycle
//             last_o
//   config    cfg_valid_i cfg_ready_o cfg_index_i cfg_data_i valid & ready
//
// A load is written as it is taken and leaves busy_o low. A tick issues one
// axis per cycle into an eight-stage update pipeline; busy_o falls the cycle
// after the last result appears, so no new command is taken while the axes
// of a tick are still in the pipeline.
// Reset marks every axis entry as zero; no clearing pass is needed.
// Results are not stalled; the receiver takes each one as it appears.
// ----------------------------------------------------------------------------
module joint_trapezoid_trajectory_core
  import jtt_pkg::*;
#(
  parameter int unsigned NUM_AXES      = NUM_AXES_DEF,
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         command_i,
  input  logic [AXIS_W-1:0]            axis_i,
  input  logic signed [COUNT_W-1:0]    target_counts_i,
  output logic                         result_strobe_o,
  output logic [AXIS_W-1:0]            axis_out_o,
  output logic signed [COUNT_W-1:0]    position_counts_o,
  output logic                         last_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i
);

  localparam int unsigned AW    = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam int unsigned POS_W = COUNT_W + FRACTION_BITS;
  localparam int unsigned PV_W  = POS_W + VEL_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [AW-1:0]       idx_q, idx_d;
  logic [NUM_AXES-1:0] pv_valid_q, goal_valid_q;
  logic [VMAX_W-1:0]   vmax_q;
  logic [ACCEL_W-1:0]  accel_q;

  logic accept, load_ok, tick;
  logic idx_last;

  jtt_issue_t              issue;
  logic signed [POS_W-1:0] goal_w;
  logic [PV_W-1:0]         pv_rdata;
  logic [POS_W-1:0]        goal_rdata;

  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic signed [POS_W-1:0]   wr_pos;
  logic signed [VEL_W-1:0]   wr_vel;
  jtt_res_t                  res;
  logic [AW-1:0]             res_axis;
  logic signed [COUNT_W-1:0] res_counts;

  assign busy_o   = (state_q != ST_IDLE);
  assign accept   = start_i && !busy_o;
  assign tick     = accept && (command_i == CMD_TICK);
  assign load_ok  = accept && (command_i == CMD_LOAD) && (32'(axis_i) < NUM_AXES);
  assign goal_w   = POS_W'(target_counts_i) <<< FRACTION_BITS;
  assign idx_last = (idx_q == AW'(NUM_AXES - 1));

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    issue   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (tick) begin
          state_d = ST_ISSUE;
          idx_d   = '0;
        end
      end
      ST_ISSUE: begin
        issue.vld     = 1'b1;
        issue.last    = idx_last;
        issue.pv_ok   = pv_valid_q[idx_q];
        issue.goal_ok = goal_valid_q[idx_q];
        if (idx_last) begin
          state_d = ST_DRAIN;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      ST_DRAIN: begin
        if (res.strobe && res.last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      pv_valid_q   <= '0;
      goal_valid_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (wr_en) begin
        pv_valid_q[wr_addr] <= 1'b1;
      end
      if (load_ok) begin
        goal_valid_q[AW'(axis_i)] <= 1'b1;
      end
    end
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vmax_q  <= VMAX_RESET;
      accel_q <= ACCEL_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_VMAX:  vmax_q  <= cfg_data_i[VMAX_W-1:0];
        REG_ACCEL: accel_q <= cfg_data_i[ACCEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  jtt_ram #(
    .WIDTH (PV_W),
    .DEPTH (NUM_AXES),
    .ADDR_W(AW)
  ) u_pv_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i({wr_pos, wr_vel}),
    .raddr_i(idx_q),
    .rdata_o(pv_rdata)
  );

  jtt_ram #(
    .WIDTH (POS_W),
    .DEPTH (NUM_AXES),
    .ADDR_W(AW)
  ) u_goal_ram (
    .clk_i  (clk_i),
    .we_i   (load_ok),
    .waddr_i(AW'(axis_i)),
    .wdata_i(goal_w),
    .raddr_i(idx_q),
    .rdata_o(goal_rdata)
  );

  jtt_step_pipe #(
    .AXIS_AW      (AW),
    .FRACTION_BITS(FRACTION_BITS),
    .POS_W        (POS_W)
  ) u_step_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vmax_i      (vmax_q),
    .accel_i     (accel_q),
    .issue_i     (issue),
    .issue_axis_i(idx_q),
    .pos_rd_i    ($signed(pv_rdata[PV_W-1:VEL_W])),
    .vel_rd_i    ($signed(pv_rdata[VEL_W-1:0])),
    .goal_rd_i   ($signed(goal_rdata)),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_pos_o    (wr_pos),
    .wr_vel_o    (wr_vel),
    .res_o       (res),
    .res_axis_o  (res_axis),
    .res_counts_o(res_counts)
  );

  assign result_strobe_o   = res.strobe;
  assign last_o            = res.last;
  assign axis_out_o        = AXIS_W'(res_axis);
  assign position_counts_o = res_counts;

endmodule

[rtl/jtt_ram.sv]
// ----------------------------------------------------------------------------
// jtt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module jtt_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 8,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/jtt_step_pipe.sv]
// ----------------------------------------------------------------------------
// jtt_step_pipe
// Per-axis update pipeline: braking test, velocity limit, position update
// with saturation and conversion to counts. One axis enters per cycle.
// ----------------------------------------------------------------------------
module jtt_step_pipe
  import jtt_pkg::*;
#(
  parameter int unsigned AXIS_AW       = 3,
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int unsigned POS_W         = COUNT_W + FRACTION_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [VMAX_W-1:0]         vmax_i,
  input  logic [ACCEL_W-1:0]        accel_i,
  input  jtt_issue_t                issue_i,
  input  logic [AXIS_AW-1:0]        issue_axis_i,
  input  logic signed [POS_W-1:0]   pos_rd_i,
  input  logic signed [VEL_W-1:0]   vel_rd_i,
  input  logic signed [POS_W-1:0]   goal_rd_i,
  output logic                      wr_en_o,
  output logic [AXIS_AW-1:0]        wr_addr_o,
  output logic signed [POS_W-1:0]   wr_pos_o,
  output logic signed [VEL_W-1:0]   wr_vel_o,
  output jtt_res_t                  res_o,
  output logic [AXIS_AW-1:0]        res_axis_o,
  output logic signed [COUNT_W-1:0] res_counts_o
);

  localparam int unsigned DW    = POS_W + 1;
  localparam int unsigned HI_W  = DW - MUL_LO_W;
  localparam int unsigned A2_W  = ACCEL_W + 1;
  localparam int unsigned PW    = A2_W + DW;
  localparam int unsigned SQ_W  = 2 * (VEL_W - 1);
  localparam int unsigned CMP_W = (PW > SQ_W) ? PW : SQ_W;
  localparam int unsigned DV_W  = VEL_W + 1;
  localparam logic [POS_W-1:0] FRAC_MASK = (POS_W'(1) << FRACTION_BITS) - POS_W'(1);

  jtt_issue_t         iss1_q;
  jtt_res_t           ctl_q [2:8];
  logic [AXIS_AW-1:0] ax_q  [1:8];

  // stage 1: masked read data, distance and speed magnitude
  logic signed [POS_W-1:0] pos1, goal1;
  logic signed [VEL_W-1:0] vel1;
  logic signed [DW-1:0]    dist_d;
  logic [VEL_W-1:0]        vabs1;
  logic [VEL_W-2:0]        vmag_d;

  logic signed [POS_W-1:0] pos2_q;
  logic signed [VEL_W-1:0] vel2_q;
  logic signed [DW-1:0]    dist2_q;
  logic [VEL_W-2:0]        vmag2_q;

  // stage 2: distance magnitude, speed squared
  logic [DW-1:0]   dmag_d;
  logic [SQ_W-1:0] vsq_d;

  logic signed [POS_W-1:0] pos3_q;
  logic signed [VEL_W-1:0] vel3_q;
  logic                    dneg3_q;
  logic [DW-1:0]           dmag3_q;
  logic [SQ_W-1:0]         vsq3_q;

  // stage 3: partial products of 2a*|dist|
  logic [A2_W-1:0]          a2;
  logic [A2_W+MUL_LO_W-1:0] plo_d;
  logic [A2_W+HI_W-1:0]     phi_d;

  logic signed [POS_W-1:0]  pos4_q;
  logic signed [VEL_W-1:0]  vel4_q;
  logic                     dneg4_q;
  logic [A2_W+MUL_LO_W-1:0] plo4_q;
  logic [A2_W+HI_W-1:0]     phi4_q;
  logic [SQ_W-1:0]          vsq4_q;

  // stage 4: braking test, desired velocity
  logic [CMP_W-1:0]        prod;
  logic                    brake;
  logic signed [VEL_W-1:0] vmax_s;
  logic signed [VEL_W-1:0] vdes_d;

  logic signed [POS_W-1:0] pos5_q;
  logic signed [VEL_W-1:0] vel5_q;
  logic signed [VEL_W-1:0] vdes5_q;

  // stage 5: limited velocity change
  logic signed [DV_W-1:0]  dv_raw, dv, amax;
  logic signed [DV_W-1:0]  nvel_w;
  logic signed [VEL_W-1:0] nvel_d;

  logic signed [POS_W-1:0] pos6_q;
  logic signed [VEL_W-1:0] nvel6_q;

  // stage 6: position update with saturation, write back
  logic signed [POS_W:0]   np;
  logic signed [POS_W-1:0] np_d;

  logic signed [POS_W-1:0] np7_q;

  // stage 7: truncate toward zero
  logic signed [POS_W-1:0]   rnd;
  logic signed [COUNT_W-1:0] counts_d;

  logic signed [COUNT_W-1:0] counts8_q;

  always_comb begin
    pos1   = iss1_q.pv_ok   ? pos_rd_i  : '0;
    vel1   = iss1_q.pv_ok   ? vel_rd_i  : '0;
    goal1  = iss1_q.goal_ok ? goal_rd_i : '0;
    dist_d = DW'(goal1) - DW'(pos1);
    vabs1  = vel1[VEL_W-1] ? VEL_W'(-vel1) : VEL_W'(vel1);
    vmag_d = vabs1[VEL_W-2:0];
  end

  always_comb begin
    dmag_d = dist2_q[DW-1] ? DW'(-dist2_q) : DW'(dist2_q);
    vsq_d  = SQ_W'(vmag2_q) * SQ_W'(vmag2_q);
  end

  always_comb begin
    a2    = {accel_i, 1'b0};
    plo_d = (A2_W+MUL_LO_W)'(a2) * (A2_W+MUL_LO_W)'(dmag3_q[MUL_LO_W-1:0]);
    phi_d = (A2_W+HI_W)'(a2) * (A2_W+HI_W)'(dmag3_q[DW-1:MUL_LO_W]);
  end

  always_comb begin
    prod   = (CMP_W'(phi4_q) << MUL_LO_W) + CMP_W'(plo4_q);
    brake  = prod < CMP_W'(vsq4_q);
    vmax_s = $signed({1'b0, vmax_i});
    if (brake) begin
      vdes_d = '0;
    end else if (dneg4_q) begin
      vdes_d = -vmax_s;
    end else begin
      vdes_d = vmax_s;
    end
  end

  always_comb begin
    amax   = $signed({{(DV_W-ACCEL_W){1'b0}}, accel_i});
    dv_raw = DV_W'(vdes5_q) - DV_W'(vel5_q);
    if (dv_raw > amax) begin
      dv = amax;
    end else if (dv_raw < -amax) begin
      dv = -amax;
    end else begin
      dv = dv_raw;
    end
    nvel_w = DV_W'(vel5_q) + dv;
    nvel_d = nvel_w[VEL_W-1:0];
  end

  always_comb begin
    np = (POS_W+1)'(pos6_q) + (POS_W+1)'(nvel6_q);
    if (np[POS_W] != np[POS_W-1]) begin
      np_d = np[POS_W] ? $signed({1'b1, {(POS_W-1){1'b0}}})
                       : $signed({1'b0, {(POS_W-1){1'b1}}});
    end else begin
      np_d = np[POS_W-1:0];
    end
  end

  always_comb begin
    rnd      = np7_q + $signed(np7_q[POS_W-1] ? FRAC_MASK : '0);
    counts_d = rnd[POS_W-1:FRACTION_BITS];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss1_q <= '0;
      for (int i = 2; i <= 8; i++) begin
        ctl_q[i] <= '0;
      end
    end else begin
      iss1_q   <= issue_i;
      ctl_q[2] <= '{strobe: iss1_q.vld, last: iss1_q.last};
      for (int i = 3; i <= 8; i++) begin
        ctl_q[i] <= ctl_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q[1] <= issue_axis_i;
    for (int i = 2; i <= 8; i++) begin
      ax_q[i] <= ax_q[i-1];
    end
    pos2_q    <= pos1;
    vel2_q    <= vel1;
    dist2_q   <= dist_d;
    vmag2_q   <= vmag_d;
    pos3_q    <= pos2_q;
    vel3_q    <= vel2_q;
    dneg3_q   <= dist2_q[DW-1];
    dmag3_q   <= dmag_d;
    vsq3_q    <= vsq_d;
    pos4_q    <= pos3_q;
    vel4_q    <= vel3_q;
    dneg4_q   <= dneg3_q;
    plo4_q    <= plo_d;
    phi4_q    <= phi_d;
    vsq4_q    <= vsq3_q;
    pos5_q    <= pos4_q;
    vel5_q    <= vel4_q;
    vdes5_q   <= vdes_d;
    pos6_q    <= pos5_q;
    nvel6_q   <= nvel_d;
    np7_q     <= np_d;
    counts8_q <= counts_d;
  end

  assign wr_en_o      = ctl_q[6].strobe;
  assign wr_addr_o    = ax_q[6];
  assign wr_pos_o     = np_d;
  assign wr_vel_o     = nvel6_q;
  assign res_o        = ctl_q[8];
  assign res_axis_o   = ax_q[8];
  assign res_counts_o = counts8_q;

endmodule
